@@ design/ftp_reply_framer_core_assert.svh @@
// Assertion macros for the reply framer checker
`ifndef FTP_REPLY_FRAMER_CORE_ASSERT_SVH
`define FTP_REPLY_FRAMER_CORE_ASSERT_SVH

// Checked on every rising edge outside reset
`define FTPRF_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included
`define FTPRF_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ design/ftprf_pkg.sv @@
// ----------------------------------------------------------------------------
// FTP reply framer package
// Payload types and character constants for the reply framer.
// ----------------------------------------------------------------------------
package ftprf_pkg;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       chunk_end;
   } req_type;

   typedef struct packed {
      logic [9:0] reply_code;
      logic       unframed;
   } rsp_type;

   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_UPPER_U = 8'h55;
   localparam logic [7:0] CHAR_LOWER_N = 8'h6E;
   localparam logic [7:0] CHAR_LOWER_U = 8'h75;
   localparam logic [7:0] CHAR_LOWER_F = 8'h66;

   localparam logic [9:0] QUIRK_CODE   = 10'd550;
   localparam logic [9:0] MAX_CODE     = 10'd999;
   localparam logic [5:0] QUIRK_OFS_0  = 6'd4;
   localparam logic [5:0] QUIRK_OFS_1  = 6'd5;
   localparam logic [5:0] QUIRK_OFS_2  = 6'd28;
   localparam logic [5:0] QUIRK_OFS_3  = 6'd33;
   localparam logic [5:0] FOUND_START  = 6'd4;
   localparam logic [5:0] OFS_MAX      = 6'd63;
   localparam logic [3:0] HITS_ALL     = 4'hF;
   localparam logic [1:0] LEAD_LEN     = 2'd3;
   localparam logic [2:0] LINE_SEP_POS = 3'd3;
   localparam logic [2:0] LINE_PAST    = 3'd4;

endpackage

@@ design/ftp_reply_framer_core.sv @@
// ----------------------------------------------------------------------------
// FTP reply framer core
// A result is registered into the output register, or the skid register.
// Throughput 1 byte per cycle unless the skid entry is full (req_ready low).
// Synchronous active-high reset clears state, buffer, sets quirk_enable to 1.
// ----------------------------------------------------------------------------
module ftp_reply_framer_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ftprf_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ftprf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import ftprf_pkg::*;

   logic       quirk_enable_ff;
   logic [1:0] lead_count_ff, lead_count_in;
   logic       lead_all_digits_ff, lead_all_digits_in;
   logic       in_first_chunk_ff, in_first_chunk_in;
   logic [2:0] line_offset_ff, line_offset_in;
   logic [9:0] line_digits_ff, line_digits_in;
   logic       line_digits_ok_ff, line_digits_ok_in;
   logic       pending_valid_ff, pending_valid_in;
   logic [9:0] pending_code_ff, pending_code_in;
   logic       found_valid_ff, found_valid_in;
   logic [9:0] found_code_ff, found_code_in;
   logic [5:0] found_offset_ff, found_offset_in;
   logic [3:0] found_hits_ff, found_hits_in;

   logic       out_valid_ff, out_valid_in;
   rsp_type    out_data_ff, out_data_in;
   logic       skid_valid_ff, skid_valid_in;
   rsp_type    skid_data_ff, skid_data_in;

   logic       accept;
   logic       pop;
   logic       is_digit;
   logic       is_newline;
   logic [3:0] digit_value;
   logic       do_clear;
   logic       res_valid;
   rsp_type    res_data;

   assign accept      = req_valid && req_ready;
   assign pop         = out_valid_ff && rsp_ready;
   assign req_ready   = !skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_data    = out_data_ff;
   assign is_digit    = (req_data.rx_byte >= CHAR_ZERO) && (req_data.rx_byte <= CHAR_NINE);
   assign is_newline  = (req_data.rx_byte == CHAR_NEWLINE);
   assign digit_value = req_data.rx_byte[3:0];

   always_comb begin
      lead_count_in      = lead_count_ff;
      lead_all_digits_in = lead_all_digits_ff;
      in_first_chunk_in  = in_first_chunk_ff;
      line_offset_in     = line_offset_ff;
      line_digits_in     = line_digits_ff;
      line_digits_ok_in  = line_digits_ok_ff;
      pending_valid_in   = pending_valid_ff;
      pending_code_in    = pending_code_ff;
      found_valid_in     = found_valid_ff;
      found_code_in      = found_code_ff;
      found_offset_in    = found_offset_ff;
      found_hits_in      = found_hits_ff;
      do_clear           = 1'b0;
      res_valid          = 1'b0;
      res_data.reply_code = '0;
      res_data.unframed   = 1'b0;

      if (accept) begin
         if (in_first_chunk_ff && (lead_count_ff < LEAD_LEN)) begin
            lead_all_digits_in = lead_all_digits_ff && is_digit;
            lead_count_in      = lead_count_ff + 2'd1;
         end

         if (pending_valid_ff) begin
            found_valid_in   = 1'b1;
            found_code_in    = pending_code_ff;
            pending_valid_in = 1'b0;
            pending_code_in  = '0;
            found_offset_in  = FOUND_START;
            found_hits_in    = '0;
         end else if (found_valid_ff && (found_offset_ff < OFS_MAX)) begin
            found_offset_in = found_offset_ff + 6'd1;
         end
         if (found_valid_in) begin
            if (found_offset_in == QUIRK_OFS_0 && req_data.rx_byte == CHAR_UPPER_U)
               found_hits_in[0] = 1'b1;
            if (found_offset_in == QUIRK_OFS_1 && req_data.rx_byte == CHAR_LOWER_N)
               found_hits_in[1] = 1'b1;
            if (found_offset_in == QUIRK_OFS_2 && req_data.rx_byte == CHAR_LOWER_U)
               found_hits_in[2] = 1'b1;
            if (found_offset_in == QUIRK_OFS_3 && req_data.rx_byte == CHAR_LOWER_F)
               found_hits_in[3] = 1'b1;
         end

         if (line_offset_ff < LINE_SEP_POS) begin
            if (is_digit && line_digits_ok_ff) begin
               line_digits_in = (line_digits_ff << 3) + (line_digits_ff << 1)
                              + {6'd0, digit_value};
            end else begin
               line_digits_ok_in = 1'b0;
            end
            line_offset_in = line_offset_ff + 3'd1;
         end else if (line_offset_ff == LINE_SEP_POS) begin
            if (line_digits_ok_ff && (req_data.rx_byte == CHAR_SPACE || is_newline)) begin
               pending_valid_in = 1'b1;
               pending_code_in  = line_digits_ff;
            end
            line_offset_in = LINE_PAST;
         end
         if (is_newline) begin
            line_offset_in    = '0;
            line_digits_in    = '0;
            line_digits_ok_in = 1'b1;
         end

         if (req_data.chunk_end) begin
            if (is_newline && found_valid_in) begin
               do_clear = 1'b1;
               if (!(found_code_in == QUIRK_CODE && quirk_enable_ff
                     && found_hits_in == HITS_ALL)) begin
                  res_valid           = 1'b1;
                  res_data.reply_code = found_code_in;
               end
            end else if (in_first_chunk_ff && lead_count_in == LEAD_LEN
                         && !lead_all_digits_in) begin
               do_clear          = 1'b1;
               res_valid         = 1'b1;
               res_data.unframed = 1'b1;
            end else begin
               in_first_chunk_in = 1'b0;
            end
         end

         if (do_clear) begin
            lead_count_in      = '0;
            lead_all_digits_in = 1'b1;
            in_first_chunk_in  = 1'b1;
            line_offset_in     = '0;
            line_digits_in     = '0;
            line_digits_ok_in  = 1'b1;
            pending_valid_in   = 1'b0;
            pending_code_in    = '0;
            found_valid_in     = 1'b0;
            found_code_in      = '0;
            found_offset_in    = '0;
            found_hits_in      = '0;
         end
      end
   end

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop) begin
         out_valid_in  = skid_valid_ff;
         out_data_in   = skid_data_ff;
         skid_valid_in = 1'b0;
      end
      if (res_valid) begin
         if (out_valid_in) begin
            skid_valid_in = 1'b1;
            skid_data_in  = res_data;
         end else begin
            out_valid_in = 1'b1;
            out_data_in  = res_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quirk_enable_ff    <= 1'b1;
         lead_count_ff      <= '0;
         lead_all_digits_ff <= 1'b1;
         in_first_chunk_ff  <= 1'b1;
         line_offset_ff     <= '0;
         line_digits_ff     <= '0;
         line_digits_ok_ff  <= 1'b1;
         pending_valid_ff   <= 1'b0;
         pending_code_ff    <= '0;
         found_valid_ff     <= 1'b0;
         found_code_ff      <= '0;
         found_offset_ff    <= '0;
         found_hits_ff      <= '0;
         out_valid_ff       <= 1'b0;
         skid_valid_ff      <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            quirk_enable_ff <= csr_wr_data;
         end
         lead_count_ff      <= lead_count_in;
         lead_all_digits_ff <= lead_all_digits_in;
         in_first_chunk_ff  <= in_first_chunk_in;
         line_offset_ff     <= line_offset_in;
         line_digits_ff     <= line_digits_in;
         line_digits_ok_ff  <= line_digits_ok_in;
         pending_valid_ff   <= pending_valid_in;
         pending_code_ff    <= pending_code_in;
         found_valid_ff     <= found_valid_in;
         found_code_ff      <= found_code_in;
         found_offset_ff    <= found_offset_in;
         found_hits_ff      <= found_hits_in;
         out_valid_ff       <= out_valid_in;
         skid_valid_ff      <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

endmodule

@@ design/ftprf_checker.sv @@
// ----------------------------------------------------------------------------
// FTP reply framer port checker
// Checks result channel behavior seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "ftp_reply_framer_core_assert.svh"

module ftprf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input ftprf_pkg::rsp_type rsp_data
);
   import ftprf_pkg::*;

   `FTPRF_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_valid, "result valid after reset")
   `FTPRF_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "stalled result changed")
   `FTPRF_ASSERT(a_unframed_zero, rsp_valid && rsp_data.unframed |-> rsp_data.reply_code == '0, "unframed result carries a code")
   `FTPRF_ASSERT(a_code_range, rsp_valid |-> rsp_data.reply_code <= MAX_CODE, "reply code out of range")
   `FTPRF_ASSERT(a_stall_full, !req_ready |-> rsp_valid, "input stalled with no result waiting")

endmodule

bind ftp_reply_framer_core ftprf_checker u_ftprf_checker (
   .clock       (clock),
   .reset       (reset),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_data    (rsp_data)
);
